### hw/rtl/spm_pkg.sv
`timescale 1ns / 1ps

package spm_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int MAX_TEXT_DEF    = 1048576;

    localparam int CHAR_W   = 8;
    localparam int LEN_W    = 5;
    localparam int WORD_W   = 64;
    localparam int POS_W    = 20;
    localparam int CFG_IDX_W = 2;

    // largest pattern the two config words can hold
    localparam int PATTERN_SLOTS = 16;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_LOW      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARS_HIGH     = 2'd2;

    localparam logic [LEN_W-1:0] PATTERN_LENGTH_RESET = 5'd1;

    typedef struct packed {
        logic [POS_W-1:0] start;
    } match_rec_t;

    // byte i of the pattern, low word holds bytes 0..7
    function automatic logic [CHAR_W-1:0] pattern_byte(
        input logic [WORD_W-1:0] lo,
        input logic [WORD_W-1:0] hi,
        input logic [3:0]        idx
    );
        logic [WORD_W-1:0] word;
        word = idx[3] ? hi : lo;
        return word[{idx[2:0], 3'b000} +: CHAR_W];
    endfunction

endpackage

### hw/rtl/spm_if.sv
`timescale 1ns / 1ps

interface spm_text_if;
    logic                           valid;
    logic                           ready;
    logic [spm_pkg::CHAR_W-1:0]     text_char;
    logic                           last_of_text;

    modport source (output valid, output text_char, output last_of_text, input ready);
    modport sink   (input valid, input text_char, input last_of_text, output ready);
endinterface

interface spm_match_if;
    logic                           valid;
    logic                           ready;
    logic [spm_pkg::POS_W-1:0]      match_start;

    modport source (output valid, output match_start, input ready);
    modport sink   (input valid, input match_start, output ready);
endinterface

interface spm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [spm_pkg::CFG_IDX_W-1:0]  index;
    logic [spm_pkg::WORD_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/spm_front.sv
`timescale 1ns / 1ps

module spm_front #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = spm_pkg::MAX_TEXT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    spm_text_if.sink            text,
    spm_cfg_if.sink             cfg,
    input  logic                queue_ready,
    output logic                push,
    output spm_pkg::match_rec_t push_rec
);

    localparam int SEEN_W = $clog2(MAX_PATTERN + 1);
    localparam longint CAP_RAW = longint'(MAX_TEXT) - 1;
    localparam logic [spm_pkg::POS_W-1:0] POS_CAP =
        (CAP_RAW > longint'((1 << spm_pkg::POS_W) - 1)) ?
        {spm_pkg::POS_W{1'b1}} : spm_pkg::POS_W'(CAP_RAW);
    localparam logic [spm_pkg::LEN_W-1:0] DEPTH_LEN = spm_pkg::LEN_W'(MAX_PATTERN);

    logic [spm_pkg::LEN_W-1:0]   pattern_length_reg;
    logic [spm_pkg::WORD_W-1:0]  chars_low_reg;
    logic [spm_pkg::WORD_W-1:0]  chars_high_reg;

    logic [spm_pkg::CHAR_W-1:0]  window_reg  [MAX_PATTERN];
    logic [spm_pkg::CHAR_W-1:0]  window_next [MAX_PATTERN];
    logic [SEEN_W-1:0]           seen_reg;
    logic [SEEN_W-1:0]           seen_next;
    logic [spm_pkg::POS_W-1:0]   pos_reg;
    logic [spm_pkg::POS_W-1:0]   pos_next;

    logic                        accept;
    logic [spm_pkg::LEN_W-1:0]   len_eff;
    logic [spm_pkg::POS_W-1:0]   len_m1;
    logic [MAX_PATTERN-1:0]      byte_ok;
    logic                        hit;

    assign cfg.ready  = 1'b1;
    assign text.ready = queue_ready;
    assign accept     = text.valid && queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_length_reg <= spm_pkg::PATTERN_LENGTH_RESET;
            chars_low_reg      <= '0;
            chars_high_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                spm_pkg::REG_PATTERN_LENGTH:
                    pattern_length_reg <= cfg.data[spm_pkg::LEN_W-1:0];
                spm_pkg::REG_CHARS_LOW:  chars_low_reg  <= cfg.data;
                spm_pkg::REG_CHARS_HIGH: chars_high_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign len_eff = (pattern_length_reg > DEPTH_LEN) ? DEPTH_LEN : pattern_length_reg;
    assign len_m1  = spm_pkg::POS_W'(len_eff) - spm_pkg::POS_W'(1);

    // newest byte sits in slot 0
    assign window_next[0] = text.text_char;
    for (genvar k = 1; k < MAX_PATTERN; k++)
    begin : g_shift
        assign window_next[k] = window_reg[k-1];
    end

    // slot k holds pattern byte len-1-k; slots past the length always agree
    for (genvar k = 0; k < MAX_PATTERN; k++)
    begin : g_cmp
        logic [spm_pkg::LEN_W-1:0] pidx;
        assign pidx = len_eff - spm_pkg::LEN_W'(1) - spm_pkg::LEN_W'(k);
        assign byte_ok[k] = (spm_pkg::LEN_W'(k) >= len_eff) ||
            (window_next[k] ==
             spm_pkg::pattern_byte(chars_low_reg, chars_high_reg, pidx[3:0]));
    end

    assign seen_next = (seen_reg < SEEN_W'(MAX_PATTERN)) ? seen_reg + SEEN_W'(1) : seen_reg;
    assign pos_next  = (pos_reg < POS_CAP) ? pos_reg + spm_pkg::POS_W'(1) : pos_reg;

    assign hit = (len_eff != '0) && (spm_pkg::LEN_W'(seen_next) >= len_eff) && (&byte_ok);

    assign push           = accept && hit;
    assign push_rec.start = (pos_reg >= len_m1) ? pos_reg - len_m1 : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PATTERN; i++)
            begin
                window_reg[i] <= '0;
            end
            seen_reg <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            if (text.last_of_text)
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    window_reg[i] <= '0;
                end
                seen_reg <= '0;
                pos_reg  <= '0;
            end
            else
            begin
                for (int i = 0; i < MAX_PATTERN; i++)
                begin
                    window_reg[i] <= window_next[i];
                end
                seen_reg <= seen_next;
                pos_reg  <= pos_next;
            end
        end
    end

endmodule

### hw/rtl/spm_queue.sv
`timescale 1ns / 1ps

module spm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  spm_pkg::match_rec_t push_rec,
    output logic                not_full,
    input  logic                pop,
    output logic                not_empty,
    output spm_pkg::match_rec_t head_rec
);

    localparam int DEPTH = spm_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    spm_pkg::match_rec_t entries [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_rec  = entries[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> not_full)
        else $error("push into full queue");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("queue count did not follow push");

endmodule

### hw/rtl/spm_back.sv
`timescale 1ns / 1ps

module spm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                not_empty,
    input  spm_pkg::match_rec_t head_rec,
    output logic                pop,
    spm_match_if.source         match
);

    logic                       valid_reg;
    logic [spm_pkg::POS_W-1:0]  start_reg;
    logic                       load;

    // refill whenever the output beat is empty or leaving this cycle
    assign load = !valid_reg || match.ready;
    assign pop  = load && not_empty;

    assign match.valid       = valid_reg;
    assign match.match_start = start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            start_reg <= head_rec.start;
        end
    end

endmodule

### hw/rtl/streaming_pattern_matcher.sv
`timescale 1ns / 1ps
// a byte's match is written into the match queue as the byte is accepted, then moves to the output register
// throughput: one text byte per cycle while the match queue is not full, set by the combinational window compare
// the front stalls only when the four-entry match queue is full under output backpressure
// reset (rst_n, async, active low): pattern length 1, pattern bytes zero,
// window, byte count, text position and match queue cleared

module streaming_pattern_matcher #(
    parameter int MAX_PATTERN = spm_pkg::MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = spm_pkg::MAX_TEXT_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    spm_text_if.sink     text,
    spm_cfg_if.sink      cfg,
    spm_match_if.source  match
);

    logic                queue_ready;
    logic                push;
    spm_pkg::match_rec_t push_rec;
    logic                pop;
    logic                not_empty;
    spm_pkg::match_rec_t head_rec;

    spm_front #(
        .MAX_PATTERN (MAX_PATTERN),
        .MAX_TEXT    (MAX_TEXT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text),
        .cfg         (cfg),
        .queue_ready (queue_ready),
        .push        (push),
        .push_rec    (push_rec)
    );

    spm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .not_full  (queue_ready),
        .pop       (pop),
        .not_empty (not_empty),
        .head_rec  (head_rec)
    );

    spm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head_rec  (head_rec),
        .pop       (pop),
        .match     (match)
    );

endmodule
